>>> rtl/core/usmf_pkg.sv
// ----------------------------------------------------------------------------
// usmf_pkg
// shared widths, reset values, register map and types of the range filter
// ----------------------------------------------------------------------------
package usmf_pkg;

    localparam int ECHO_W    = 16;
    localparam int DIST_W    = 19;
    localparam int LEVEL_W   = 16;
    localparam int SCALE_W   = 11;
    localparam int PROD_W    = ECHO_W + SCALE_W;
    localparam int FRAC_W    = 8;
    localparam int COUNT_W   = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 56;
    localparam int M_USER_W  = 2;

    localparam int BURST_LEN_DEF = 3;

    localparam logic [SCALE_W-1:0] DIST_SCALE   = SCALE_W'(1124);
    localparam logic [DIST_W-1:0]  MIN_DIST_RST = DIST_W'(512);
    localparam logic [DIST_W-1:0]  MAX_DIST_RST = DIST_W'(102400);
    localparam logic [DIST_W-1:0]  STOP_DIST_RST = DIST_W'(2560);
    localparam logic [LEVEL_W-1:0] RUN_LEVEL_RST = LEVEL_W'(58981);

    typedef enum logic [1:0] {
        REG_MIN_DIST  = 2'd0,
        REG_MAX_DIST  = 2'd1,
        REG_STOP_DIST = 2'd2,
        REG_RUN_LEVEL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  max_dist;
        logic [DIST_W-1:0]  stop_dist;
        logic [LEVEL_W-1:0] run_level;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]  sample_distance;
        logic               sample_ok;
        logic               burst_done;
        logic [DIST_W-1:0]  med_dist;
        logic               median_ok;
        logic               stop_motors;
        logic [LEVEL_W-1:0] drive_level;
    } res_t;

endpackage

>>> rtl/core/usmf_burst.sv
// ----------------------------------------------------------------------------
// usmf_burst
// distance conversion, window check, burst state and median stop decision
// ----------------------------------------------------------------------------
module usmf_burst #(
    parameter int BURST_LEN = usmf_pkg::BURST_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [usmf_pkg::ECHO_W-1:0]   echo_us,
    input  usmf_pkg::cfg_t                cfg,
    output usmf_pkg::res_t                res
);
    import usmf_pkg::*;

    localparam int BLEN   = (BURST_LEN < 1) ? 1 : ((BURST_LEN > 3) ? 3 : BURST_LEN);
    localparam int SLOT_W = $clog2(BLEN + 1);
    localparam int KEEP_N = 3;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEVEL_W-1:0] applied_reg, applied_next;
    logic [DIST_W-1:0]  keep_reg [KEEP_N];
    logic [DIST_W-1:0]  keep_now [KEEP_N];
    logic [KEEP_N-1:0]  keep_wr;

    logic [PROD_W-1:0]  prod;
    logic [DIST_W-1:0]  sample_dist;
    logic               ok;
    logic               done;
    logic [COUNT_W-1:0] n_kept;
    logic [DIST_W-1:0]  lo_ab, hi_ab, mid_c, med3, med;
    logic               stop;

    assign prod        = PROD_W'(echo_us) * PROD_W'(DIST_SCALE);
    assign sample_dist = prod[FRAC_W +: DIST_W];
    assign ok          = (sample_dist >= cfg.min_dist) && (sample_dist <= cfg.max_dist);

    always_comb begin
        for (int i = 0; i < KEEP_N; i++) begin
            keep_wr[i]  = ok && (count_reg == COUNT_W'(i));
            keep_now[i] = keep_wr[i] ? sample_dist : keep_reg[i];
        end
    end

    assign n_kept = (|keep_wr) ? count_reg + COUNT_W'(1) : count_reg;
    assign done   = (slot_reg == SLOT_W'(BLEN - 1));

    // median network over the three slots
    assign lo_ab = (keep_now[0] < keep_now[1]) ? keep_now[0] : keep_now[1];
    assign hi_ab = (keep_now[0] > keep_now[1]) ? keep_now[0] : keep_now[1];
    assign mid_c = (hi_ab < keep_now[2]) ? hi_ab : keep_now[2];
    assign med3  = (lo_ab > mid_c) ? lo_ab : mid_c;

    always_comb begin
        case (n_kept)
            COUNT_W'(0): med = '0;
            COUNT_W'(1): med = keep_now[0];
            COUNT_W'(2): med = hi_ab;
            default:     med = med3;
        endcase
    end

    assign stop = done && (n_kept != '0) && (med <= cfg.stop_dist);

    always_comb begin
        slot_next    = slot_reg;
        count_next   = n_kept;
        applied_next = applied_reg;
        if (done) begin
            slot_next    = '0;
            count_next   = '0;
            applied_next = stop ? '0 : cfg.run_level;
        end else begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            count_reg   <= '0;
            applied_reg <= RUN_LEVEL_RST;
        end else if (step) begin
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            applied_reg <= applied_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEEP_N; i++) begin
            if (step && keep_wr[i]) begin
                keep_reg[i] <= sample_dist;
            end
        end
    end

    always_comb begin
        res.sample_distance = sample_dist;
        res.sample_ok       = ok;
        res.burst_done      = done;
        res.median_ok       = done && (n_kept != '0);
        res.med_dist        = res.median_ok ? med : '0;
        res.stop_motors     = stop;
        res.drive_level     = applied_next;
    end

endmodule

>>> rtl/core/ultrasonic_median_stop_filter_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_median_stop_filter_core
// echo width to distance, valid window, median of each burst, motor stop
// pipeline: input transfer to result through the input register and the result register
// throughput: one transfer per cycle; input stalls only while both registers are
// full and m_tready is low
// reset: synchronous, active low; clears pipeline valids, burst slot and kept count,
// loads register defaults and the run level as applied level
// ----------------------------------------------------------------------------
module ultrasonic_median_stop_filter_core #(
    parameter int BURST_LEN = usmf_pkg::BURST_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // [15:0] echo_us
    input  logic [usmf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [18:0] sample_distance, [37:19] median of the burst, [38] stop_motors,
    // [54:39] drive_level, [55] zero
    output logic [usmf_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] sample_ok, [1] median_ok
    output logic [usmf_pkg::M_USER_W-1:0]   m_tuser,
    // burst_done
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [usmf_pkg::APB_AW-1:0]     paddr,
    input  logic [usmf_pkg::APB_DW-1:0]     pwdata,
    output logic [usmf_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import usmf_pkg::*;

    cfg_t               cfg_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    logic               in_valid_reg;
    logic [ECHO_W-1:0]  in_echo_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res;
    logic               adv;
    logic               step;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_dist  <= MIN_DIST_RST;
            cfg_reg.max_dist  <= MAX_DIST_RST;
            cfg_reg.stop_dist <= STOP_DIST_RST;
            cfg_reg.run_level <= RUN_LEVEL_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_DIST:  cfg_reg.min_dist  <= pwdata[DIST_W-1:0];
                REG_MAX_DIST:  cfg_reg.max_dist  <= pwdata[DIST_W-1:0];
                REG_STOP_DIST: cfg_reg.stop_dist <= pwdata[DIST_W-1:0];
                REG_RUN_LEVEL: cfg_reg.run_level <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_DIST:  prdata = APB_DW'(cfg_reg.min_dist);
            REG_MAX_DIST:  prdata = APB_DW'(cfg_reg.max_dist);
            REG_STOP_DIST: prdata = APB_DW'(cfg_reg.stop_dist);
            REG_RUN_LEVEL: prdata = APB_DW'(cfg_reg.run_level);
            default:       prdata = '0;
        endcase
    end

    // two-stage pipeline
    assign adv      = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_echo_reg <= s_tdata[ECHO_W-1:0];
        end
        if (step) begin
            out_reg <= res;
        end
    end

    usmf_burst #(
        .BURST_LEN (BURST_LEN)
    ) u_burst (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .echo_us (in_echo_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.burst_done;
    assign m_tuser  = {out_reg.median_ok, out_reg.sample_ok};
    assign m_tdata  = {1'b0, out_reg.drive_level, out_reg.stop_motors,
                       out_reg.med_dist, out_reg.sample_distance};

    // checks
    a_stop_needs_median: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.stop_motors |->
            out_reg.median_ok && out_reg.burst_done && (out_reg.drive_level == '0))
        else $error("stop without median at burst end");

    a_mid_burst_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.burst_done |->
            !out_reg.median_ok && !out_reg.stop_motors && (out_reg.med_dist == '0))
        else $error("decision fields set mid burst");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in pipeline");

    a_run_level_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.burst_done && !res.stop_motors |=>
            out_reg.drive_level == $past(cfg_reg.run_level))
        else $error("run level not applied at burst end");

endmodule

>>> sim/tb_ultrasonic_median_stop_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_median_stop_filter_core
// self-checking bench for the echo range filter: echo widths go in as stream
// transfers, each result is checked field by field against an in-bench model
// of the distance scaling, valid window, burst median and stop decision, over
// several register settings with random idling on both sides of the core
// ----------------------------------------------------------------------------
module tb_ultrasonic_median_stop_filter_core;
    import usmf_pkg::*;

class range_scoreboard;
    localparam int BURST = BURST_LEN_DEF;

    logic [DIST_W-1:0]  min_d;
    logic [DIST_W-1:0]  max_d;
    logic [DIST_W-1:0]  stop_d;
    logic [LEVEL_W-1:0] run_lvl;

    int                 slot;
    int                 n_kept;
    logic [DIST_W-1:0]  kept[3];
    logic [LEVEL_W-1:0] applied;

    res_t               expected_q[$];
    int                 errors;
    int                 n_echoes;
    int                 n_bursts;
    int                 n_stops;
    int                 n_empty;
    int                 n_writes;

    function new();
        min_d    = MIN_DIST_RST;
        max_d    = MAX_DIST_RST;
        stop_d   = STOP_DIST_RST;
        run_lvl  = RUN_LEVEL_RST;
        applied  = RUN_LEVEL_RST;
        slot     = 0;
        n_kept   = 0;
        kept     = '{default: '0};
        errors   = 0;
        n_echoes = 0;
        n_bursts = 0;
        n_stops  = 0;
        n_empty  = 0;
        n_writes = 0;
    endfunction

    function void report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
        n_writes++;
        case (idx)
            REG_MIN_DIST:  min_d   = value[DIST_W-1:0];
            REG_MAX_DIST:  max_d   = value[DIST_W-1:0];
            REG_STOP_DIST: stop_d  = value[DIST_W-1:0];
            REG_RUN_LEVEL: run_lvl = value[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [DIST_W-1:0] median_of(int n);
        logic [DIST_W-1:0] lo_ab;
        logic [DIST_W-1:0] hi_ab;
        lo_ab = (kept[0] < kept[1]) ? kept[0] : kept[1];
        hi_ab = (kept[0] > kept[1]) ? kept[0] : kept[1];
        if (n == 1)
            return kept[0];
        if (n == 2)
            return hi_ab;
        return (lo_ab > ((hi_ab < kept[2]) ? hi_ab : kept[2])) ?
               lo_ab : ((hi_ab < kept[2]) ? hi_ab : kept[2]);
    endfunction

    function void note_echo(logic [ECHO_W-1:0] us);
        res_t        r;
        int unsigned prod;
        prod = 32'(us) * 32'(DIST_SCALE);
        r = '0;
        r.sample_distance = DIST_W'(prod >> FRAC_W);
        r.sample_ok = (r.sample_distance >= min_d) && (r.sample_distance <= max_d);
        if (r.sample_ok && n_kept < 3) begin
            kept[n_kept] = r.sample_distance;
            n_kept++;
        end
        r.burst_done = (slot + 1 >= BURST);
        if (r.burst_done) begin
            n_bursts++;
            if (n_kept > 0) begin
                r.median_ok   = 1'b1;
                r.med_dist    = median_of(n_kept);
                r.stop_motors = (r.med_dist <= stop_d);
            end else begin
                n_empty++;
            end
            if (r.stop_motors)
                n_stops++;
            applied = r.stop_motors ? '0 : run_lvl;
            slot    = 0;
            n_kept  = 0;
        end else begin
            slot++;
        end
        r.drive_level = applied;
        n_echoes++;
        expected_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned got, int unsigned want, int seq);
        if (got != want)
            report($sformatf("result %0d %s got %0h expected %0h", seq, name, got, want));
    endfunction

    function void check_result(res_t got);
        res_t want;
        int   seq;
        if (expected_q.size() == 0) begin
            report("result with no echo outstanding");
            return;
        end
        seq  = n_echoes - expected_q.size();
        want = expected_q.pop_front();
        cmp("sample_distance", got.sample_distance, want.sample_distance, seq);
        cmp("sample_ok", got.sample_ok, want.sample_ok, seq);
        cmp("burst_done", got.burst_done, want.burst_done, seq);
        cmp("med_dist", got.med_dist, want.med_dist, seq);
        cmp("median_ok", got.median_ok, want.median_ok, seq);
        cmp("stop_motors", got.stop_motors, want.stop_motors, seq);
        cmp("drive_level", got.drive_level, want.drive_level, seq);
    endfunction
endclass

    localparam int PHASES          = 12;
    localparam int PHASE_ECHOES    = 61;
    localparam int PRESSURE_PHASE  = 3;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    range_scoreboard       sb;
    bit                    tx_calm;
    bit                    rx_calm;
    bit                    hold_req;
    int                    rx_wait;
    int                    quiet_cycles;

    ultrasonic_median_stop_filter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned echo_for(logic [DIST_W-1:0] d);
        int unsigned us;
        us = (32'(d) * 256) / 32'(DIST_SCALE);
        return (us > 65535) ? 65535 : us;
    endfunction

    function automatic logic [ECHO_W-1:0] pick_echo();
        int unsigned lo;
        int unsigned hi;
        int unsigned st;
        lo = echo_for(sb.min_d);
        hi = echo_for(sb.max_d) + 1;
        st = echo_for(sb.stop_d);
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (lo <= hi)
                    return ECHO_W'($urandom_range(hi, lo));
                return ECHO_W'($urandom);
            end
            5, 6:
                return ECHO_W'($urandom_range((st > 65515) ? 65535 : st + 20,
                                              (st > 20) ? st - 20 : 0));
            7: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return ECHO_W'(1);
                    default: return ECHO_W'(65534);
                endcase
            end
            default:
                return ECHO_W'($urandom);
        endcase
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (hold_req) begin
                rx_wait  = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm)
                    rx_wait = idle_len();
            end
        end
    end

    // transfer monitor: feeds the model, checks results, tracks activity
    always @(posedge aclk) begin
        res_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_echo(s_tdata[ECHO_W-1:0]);
            if (psel && penable && pwrite && pready)
                sb.write_reg(reg_idx_t'(paddr[3:2]), pwdata);
            if (m_tvalid && m_tready) begin
                got.sample_distance = m_tdata[18:0];
                got.med_dist        = m_tdata[37:19];
                got.stop_motors     = m_tdata[38];
                got.drive_level     = m_tdata[54:39];
                got.sample_ok       = m_tuser[0];
                got.median_ok       = m_tuser[1];
                got.burst_done      = m_tlast;
                sb.check_result(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("stalled for %0d cycles with no transfer", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_echo(input logic [ECHO_W-1:0] us);
        int gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_DATA_W'(us);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi,
                              input logic [DIST_W-1:0] st, input logic [LEVEL_W-1:0] lvl);
        apb_write(REG_MIN_DIST, APB_DW'(lo));
        apb_write(REG_MAX_DIST, APB_DW'(hi));
        apb_write(REG_STOP_DIST, APB_DW'(st));
        apb_write(REG_RUN_LEVEL, APB_DW'(lvl));
    endtask

    initial begin
        logic [ECHO_W-1:0] directed[$];
        sb = new();
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tdata  <= '0;
        s_tvalid <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window: full burst to stop, single kept, none kept, two kept,
        // window edges, saturated echoes
        directed = '{117, 300, 5000,
                     0, 65535, 20000,
                     0, 0, 0,
                     116, 583, 400,
                     23322, 23323, 584,
                     65535, 65535, 65535,
                     1000, 2000};
        foreach (directed[i])
            send_echo(directed[i]);
        // new run level written mid-burst only shows at the burst end
        settle();
        apb_write(REG_RUN_LEVEL, APB_DW'(16'd1234));
        send_echo(16'd3000);

        for (int p = 0; p < PHASES; p++) begin
            logic [DIST_W-1:0] lo;
            logic [DIST_W-1:0] hi;
            settle();
            case (p)
                0: set_window('0, '1, '0, '1);
                1: set_window('1, '0, '1, '0);
                2: set_window('0, '0, '1, 16'h5555);
                3: set_window(MIN_DIST_RST, MAX_DIST_RST, STOP_DIST_RST, RUN_LEVEL_RST);
                4: set_window(DIST_W'(287739), '1, DIST_W'(524286), 16'hAAAA);
                default: begin
                    lo = DIST_W'($urandom_range(0, 40000));
                    hi = DIST_W'(lo + $urandom_range(0, 250000));
                    if ($urandom_range(0, 5) == 0)
                        hi = DIST_W'($urandom_range(0, lo));
                    set_window(lo, hi, DIST_W'($urandom_range(0, 120000)),
                               LEVEL_W'($urandom));
                end
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (p == PRESSURE_PHASE) begin
                tx_calm  = 1'b1;
                hold_req = 1'b1;
            end
            repeat (PHASE_ECHOES)
                send_echo(pick_echo());
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (10) @(posedge aclk);

        $display("checked %0d echo results in %0d bursts, %0d register writes",
                 sb.n_echoes, sb.n_bursts, sb.n_writes);
        $display("bursts ending in a stop: %0d, bursts with nothing kept: %0d",
                 sb.n_stops, sb.n_empty);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
